// ----- sv/voxel_spiral_index_generator_assert.svh -----
// Assertion macros used by the checker file of the spiral index generator.
// Each macro expands to one labeled concurrent assertion, gated off in reset.
`ifndef VOXEL_SPIRAL_INDEX_GENERATOR_ASSERT_SVH
`define VOXEL_SPIRAL_INDEX_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define VSIG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VSIG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/vsig_pkg.sv -----
// ----------------------------------------------------------------------------
// vsig_pkg
// Shared types and constants of the voxel spiral index generator.
// ----------------------------------------------------------------------------
package vsig_pkg;

  localparam int SIZE_W    = 9;   // config register width
  localparam int CTR_W     = 8;   // shell / plane counters, centers
  localparam int CUR_W     = 10;  // signed ring cursor
  localparam int SW_W      = 11;  // signed working width for coordinates
  localparam int IDX_W     = 24;  // output index width
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd16;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL1,
    ST_MUL2,
    ST_RESULT
  } vsig_state_t;

  typedef struct packed {
    logic accept;    // request taken this cycle
    logic step;      // evaluate and advance one walk position
    logic mul1;      // z*sy + y
    logic mul2;      // (..)*sx + x
    logic load_out;  // copy result into output register
  } vsig_cmd_t;

  typedef struct packed {
    logic exh;  // walk has no positions left
    logic hit;  // current position lies in the volume
  } vsig_status_t;

endpackage

// ----- sv/vsig_datapath.sv -----
// ----------------------------------------------------------------------------
// vsig_datapath
// Size registers, walk state, position test, ring stepping and index multiply.
// ----------------------------------------------------------------------------
module vsig_datapath #(
  parameter int MAX_SIZE = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [vsig_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vsig_pkg::SIZE_W-1:0]      cfg_data,
  input  logic                             restart,
  input  vsig_pkg::vsig_cmd_t              cmd,
  output vsig_pkg::vsig_status_t           status,
  output logic [vsig_pkg::IDX_W-1:0]       voxel_index,
  output logic                             exhausted
);

  localparam logic [10:0] MAX_SIZE_W = 11'(MAX_SIZE);

  // configuration
  logic [vsig_pkg::SIZE_W-1:0] size_x, size_y, size_z;
  logic [vsig_pkg::SIZE_W-1:0] sx, sy, sz;
  logic [vsig_pkg::CTR_W-1:0]  cx, cy, cz, maxs, r;

  // walk state
  logic [vsig_pkg::CTR_W-1:0] shell_number, shell_number_next;
  logic [vsig_pkg::CTR_W-1:0] plane_step, plane_step_next;
  logic                       plane_below, plane_below_next;
  logic [2:0]                 ring_side, ring_side_next;
  logic [vsig_pkg::CUR_W-1:0] cursor_x, cursor_x_next;
  logic [vsig_pkg::CUR_W-1:0] cursor_y, cursor_y_next;
  logic                       walk_done, walk_done_next;

  // position test
  logic signed [vsig_pkg::SW_W-1:0] rs, z_s, x_s, y_s, cur_x_w, cur_y_w;
  logic zero_size, plane_ok, in_xy, exh;

  // next-plane and ring stepping
  logic [vsig_pkg::CTR_W-1:0] np_shell, np_step;
  logic                       np_below;
  logic                       use_np;
  logic [2:0]                 adv_side;
  logic signed [vsig_pkg::SW_W-1:0] adv_x, adv_y;

  // index pipeline
  logic [vsig_pkg::SIZE_W-1:0] z_cap, y_cap, x_cap;
  logic [17:0]                 prod1;
  logic [26:0]                 prod2;
  logic [vsig_pkg::IDX_W-1:0]  res_idx;
  logic                        res_exh;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= vsig_pkg::SIZE_RESET;
      size_y <= vsig_pkg::SIZE_RESET;
      size_z <= vsig_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        vsig_pkg::REG_SIZE_X: size_x <= cfg_data;
        vsig_pkg::REG_SIZE_Y: size_y <= cfg_data;
        vsig_pkg::REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to MAX_SIZE; clamped value is below the register value so it fits
  assign sx = ({2'b0, size_x} > MAX_SIZE_W) ? MAX_SIZE_W[8:0] : size_x;
  assign sy = ({2'b0, size_y} > MAX_SIZE_W) ? MAX_SIZE_W[8:0] : size_y;
  assign sz = ({2'b0, size_z} > MAX_SIZE_W) ? MAX_SIZE_W[8:0] : size_z;
  assign cx = sx[8:1];
  assign cy = sy[8:1];
  assign cz = sz[8:1];

  always_comb begin
    maxs = cx;
    if (cy > maxs) maxs = cy;
    if (cz > maxs) maxs = cz;
  end

  assign zero_size = (sx == '0) || (sy == '0) || (sz == '0);
  assign r         = shell_number - plane_step;
  assign rs        = $signed({3'b0, r});
  assign cur_x_w   = $signed({cursor_x[vsig_pkg::CUR_W-1], cursor_x});
  assign cur_y_w   = $signed({cursor_y[vsig_pkg::CUR_W-1], cursor_y});

  assign z_s = plane_below ? ($signed({3'b0, cz}) - $signed({3'b0, plane_step}))
                           : ($signed({3'b0, cz}) + $signed({3'b0, plane_step}));
  assign x_s = $signed({3'b0, cx}) + cur_x_w;
  assign y_s = $signed({3'b0, cy}) + cur_y_w;

  assign plane_ok = !z_s[vsig_pkg::SW_W-1] && (z_s < $signed({2'b0, sz})) &&
                    ((({2'b0, cx} + {2'b0, r}) < {1'b0, sx}) || (cx >= r) ||
                     (({2'b0, cy} + {2'b0, r}) < {1'b0, sy}) || (cy >= r));
  assign in_xy = !x_s[vsig_pkg::SW_W-1] && (x_s < $signed({2'b0, sx})) &&
                 !y_s[vsig_pkg::SW_W-1] && (y_s < $signed({2'b0, sy}));

  assign exh        = walk_done || zero_size || (shell_number >= maxs);
  assign status.exh = exh;
  assign status.hit = !exh && plane_ok && in_xy;

  // successor plane in shell order
  always_comb begin
    np_shell = shell_number;
    np_step  = plane_step;
    np_below = 1'b0;
    if (plane_step == '0) begin
      if (shell_number != '0) np_step = 8'd1;
      else np_shell = shell_number + 8'd1;
    end else if (!plane_below) begin
      np_below = 1'b1;
    end else if (plane_step < shell_number) begin
      np_step = plane_step + 8'd1;
    end else begin
      np_shell = shell_number + 8'd1;
      np_step  = '0;
    end
  end

  // one step along the ring of radius r
  always_comb begin
    use_np   = 1'b0;
    adv_side = ring_side;
    adv_x    = cur_x_w;
    adv_y    = cur_y_w;
    if (r == '0) begin
      use_np = 1'b1;
    end else begin
      case (ring_side)
        3'd0: begin
          if (cur_y_w < rs) adv_y = cur_y_w + 11'sd1;
          else begin
            adv_side = 3'd1;
            adv_x    = rs - 11'sd1;
          end
        end
        3'd1: begin
          if (cur_x_w > -rs) adv_x = cur_x_w - 11'sd1;
          else begin
            adv_side = 3'd2;
            adv_y    = rs - 11'sd1;
          end
        end
        3'd2: begin
          if (cur_y_w > -rs) adv_y = cur_y_w - 11'sd1;
          else begin
            adv_side = 3'd3;
            adv_x    = -rs + 11'sd1;
          end
        end
        3'd3: begin
          if (cur_x_w < rs) adv_x = cur_x_w + 11'sd1;
          else if (r >= 8'd2) begin
            adv_side = 3'd4;
            adv_y    = -rs + 11'sd1;
          end else use_np = 1'b1;
        end
        default: begin
          if (cur_y_w < -11'sd1) adv_y = cur_y_w + 11'sd1;
          else use_np = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    shell_number_next = shell_number;
    plane_step_next   = plane_step;
    plane_below_next  = plane_below;
    ring_side_next    = ring_side;
    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    walk_done_next    = walk_done;
    if (cmd.accept && restart) begin
      shell_number_next = '0;
      plane_step_next   = '0;
      plane_below_next  = 1'b0;
      ring_side_next    = '0;
      cursor_x_next     = '0;
      cursor_y_next     = '0;
      walk_done_next    = 1'b0;
    end else if (cmd.step && !walk_done) begin
      if (exh) begin
        walk_done_next = 1'b1;
      end else if (!plane_ok || use_np) begin
        shell_number_next = np_shell;
        plane_step_next   = np_step;
        plane_below_next  = np_below;
        ring_side_next    = '0;
        cursor_x_next     = {2'b0, np_shell - np_step};
        cursor_y_next     = '0;
      end else begin
        ring_side_next = adv_side;
        cursor_x_next  = adv_x[vsig_pkg::CUR_W-1:0];
        cursor_y_next  = adv_y[vsig_pkg::CUR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shell_number <= '0;
      plane_step   <= '0;
      plane_below  <= 1'b0;
      ring_side    <= '0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      walk_done    <= 1'b0;
    end else begin
      shell_number <= shell_number_next;
      plane_step   <= plane_step_next;
      plane_below  <= plane_below_next;
      ring_side    <= ring_side_next;
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      walk_done    <= walk_done_next;
    end
  end

  // index: (z*sy + y)*sx + x, one multiply per stage
  always_ff @(posedge clk) begin
    if (cmd.step && status.hit) begin
      z_cap   <= z_s[vsig_pkg::SIZE_W-1:0];
      y_cap   <= y_s[vsig_pkg::SIZE_W-1:0];
      x_cap   <= x_s[vsig_pkg::SIZE_W-1:0];
      res_exh <= 1'b0;
    end else if (cmd.step && exh) begin
      res_idx <= '0;
      res_exh <= 1'b1;
    end
    if (cmd.mul1) prod1 <= ({9'b0, z_cap} * {9'b0, sy}) + {9'b0, y_cap};
    if (cmd.mul2) res_idx <= prod2[vsig_pkg::IDX_W-1:0];
    if (cmd.load_out) begin
      voxel_index <= res_idx;
      exhausted   <= res_exh;
    end
  end

  assign prod2 = ({9'b0, prod1} * {18'b0, sx}) + {18'b0, x_cap};

endmodule

// ----- sv/vsig_controller.sv -----
// ----------------------------------------------------------------------------
// vsig_controller
// Sequencer for one request: walk steps, two multiply stages, result hand-off.
// ----------------------------------------------------------------------------
module vsig_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  vsig_pkg::vsig_status_t status,
  output vsig_pkg::vsig_cmd_t    cmd
);

  vsig_pkg::vsig_state_t state, state_next;
  logic                  out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vsig_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      vsig_pkg::ST_IDLE:   if (in_valid) state_next = vsig_pkg::ST_STEP;
      vsig_pkg::ST_STEP: begin
        if (status.exh) state_next = vsig_pkg::ST_RESULT;
        else if (status.hit) state_next = vsig_pkg::ST_MUL1;
      end
      vsig_pkg::ST_MUL1:   state_next = vsig_pkg::ST_MUL2;
      vsig_pkg::ST_MUL2:   state_next = vsig_pkg::ST_RESULT;
      vsig_pkg::ST_RESULT: if (!out_valid || out_ready) state_next = vsig_pkg::ST_IDLE;
      default:             state_next = vsig_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == vsig_pkg::ST_IDLE);
    cmd.accept   = (state == vsig_pkg::ST_IDLE) && in_valid;
    cmd.step     = (state == vsig_pkg::ST_STEP);
    cmd.mul1     = (state == vsig_pkg::ST_MUL1);
    cmd.mul2     = (state == vsig_pkg::ST_MUL2);
    cmd.load_out = (state == vsig_pkg::ST_RESULT) && (!out_valid || out_ready);
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

// ----- sv/voxel_spiral_index_generator.sv -----
// Flow: a request passes STEP, MUL1, MUL2 and RESULT before out_valid rises for an
//   in-volume hit (only STEP and RESULT when exhausted); STEP repeats for each clipped
//   position or skipped plane walked over. Requests are taken one at a time, only in
//   IDLE; RESULT waits while an earlier result is still held unaccepted at the port.
// Reset: rst (synchronous, active high) restores sizes to 16 and puts the walk
//   at the center; no output is valid until the first request completes.
// ----------------------------------------------------------------------------
// voxel_spiral_index_generator
// Emits linear voxel indices z*sx*sy + y*sx + x in shells around the volume
// center, one per request, or an exhausted flag once the walk is spent.
// ----------------------------------------------------------------------------
module voxel_spiral_index_generator #(
  parameter int MAX_SIZE = 256  // extents above this are clamped to it
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_write,
  input  logic [vsig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vsig_pkg::SIZE_W-1:0]    cfg_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           restart,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vsig_pkg::IDX_W-1:0]     voxel_index,
  output logic                           exhausted
);

  // Controller walks the request through: accept -> STEP (repeats while the
  // cursor sits outside the volume) -> MUL1 -> MUL2 -> RESULT. An exhausted
  // walk goes straight from STEP to RESULT with index zero.
  // The output register is separate from the walk, so a finished result can
  // sit at the port while the next request is accepted and walked.
  vsig_pkg::vsig_cmd_t    cmd;
  vsig_pkg::vsig_status_t status;

  vsig_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath holds the size registers, the shell/plane/ring walk state, the
  // in-volume test and the index multiply pipeline.
  vsig_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .restart     (restart),
    .cmd         (cmd),
    .status      (status),
    .voxel_index (voxel_index),
    .exhausted   (exhausted)
  );

endmodule

// ----- sv/vsig_checker.sv -----
// ----------------------------------------------------------------------------
// vsig_checker
// Port-level checks of the spiral index generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "voxel_spiral_index_generator_assert.svh"

module vsig_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [vsig_pkg::IDX_W-1:0]     voxel_index,
  input logic                           exhausted
);

  // an exhausted result carries index zero
  `VSIG_ASSERT_IMP(a_exh_zero, clk, rst, out_valid && exhausted, voxel_index == '0, "exhausted result with nonzero index")

  // only one request in flight: ready drops right after a request is taken
  `VSIG_ASSERT_NXT(a_one_inflight, clk, rst, in_valid && in_ready, !in_ready, "second request taken while one in flight")

  // a new result is only loaded while a request is being processed
  `VSIG_ASSERT_IMP(a_rise_busy, clk, rst, $rose(out_valid), $past(!in_ready), "result appeared with no request in flight")

  // stalled result holds
  `VSIG_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(voxel_index) && $stable(exhausted), "stalled result changed")

endmodule

bind voxel_spiral_index_generator vsig_checker u_vsig_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: voxel spiral index generator testbench
// Drives requests, some with restart, against several volume sizes, predicts every
// index of the shell walk in a local copy of the walk state, and checks each
// result in order. The sender works in bursts and the receiver stalls on its
// own schedule, including long hold-offs that back the block up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_EXTENT  = 256;    // register values above this clamp to it
  localparam int IDLE_LIMIT  = 20000;  // cycles with no handshake before giving up
  localparam int SETTLE      = 10;     // settling time after each phase
  localparam int RAND_TARGET = 525;    // directed plus random requests

  typedef logic [vsig_pkg::SIZE_W-1:0]       ext_t;
  typedef logic [vsig_pkg::IDX_W-1:0]        vidx_t;
  typedef logic [vsig_pkg::CTR_W-1:0]        ctr_t;
  typedef logic signed [vsig_pkg::CUR_W-1:0] ofs_t;

  // Ring legs of one square ring, in walk order.
  typedef enum logic [2:0] {
    LEG_RIGHT_UP,    // from (r,0) up to the top right corner
    LEG_TOP,         // leftwards along the top
    LEG_LEFT,        // down the left side
    LEG_BOTTOM,      // rightwards along the bottom
    LEG_RIGHT_TAIL   // back up the right side to (r,-1)
  } leg_t;

  typedef struct packed {
    vidx_t vidx;
    logic  spent;
  } voxel_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 cfg_write;
  logic [vsig_pkg::CFG_IDX_W-1:0]       cfg_index;
  ext_t                                 cfg_data;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic                                 restart = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  vidx_t                                voxel_index;
  logic                                 exhausted;

  voxel_spiral_index_generator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .voxel_index (voxel_index),
    .exhausted   (exhausted)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Walk predictor: local copy of the sizes and of the walk position.
  // --------------------------------------------------------------------------
  ext_t ext_x, ext_y, ext_z;
  ctr_t shell_num      = '0;            // current shell
  ctr_t plane_off      = '0;            // plane distance from the center plane
  logic on_lower_plane = 1'b0;          // 1: plane below center
  leg_t ring_leg       = LEG_RIGHT_UP;
  ofs_t ofs_x          = '0;            // cursor relative to the center
  ofs_t ofs_y          = '0;
  logic walk_spent     = 1'b0;

  function automatic int clamp_extent(input ext_t v);
    return (v > MAX_EXTENT) ? MAX_EXTENT : int'(v);
  endfunction

  function automatic void rewind_walk();
    shell_num      = '0;
    plane_off      = '0;
    on_lower_plane = 1'b0;
    ring_leg       = LEG_RIGHT_UP;
    ofs_x          = '0;
    ofs_y          = '0;
    walk_spent     = 1'b0;
  endfunction

  // Plane order within a shell: center plane, then +1/-1, +2/-2, ...
  function automatic void enter_next_plane();
    if (plane_off == '0) begin
      if (shell_num != '0) begin
        plane_off      = ctr_t'(1);
        on_lower_plane = 1'b0;
      end else begin
        shell_num = shell_num + ctr_t'(1);
      end
    end else if (!on_lower_plane) begin
      on_lower_plane = 1'b1;
    end else if (plane_off < shell_num) begin
      plane_off      = plane_off + ctr_t'(1);
      on_lower_plane = 1'b0;
    end else begin
      shell_num      = shell_num + ctr_t'(1);
      plane_off      = '0;
      on_lower_plane = 1'b0;
    end
    ring_leg = LEG_RIGHT_UP;
    ofs_x    = ofs_t'(int'(shell_num) - int'(plane_off));
    ofs_y    = '0;
  endfunction

  // One cursor step around a ring of radius r; corners are taken once.
  function automatic void step_cursor(input int r);
    int x;
    int y;
    x = ofs_x;
    y = ofs_y;
    if (r == 0) begin
      enter_next_plane();
      return;
    end
    case (ring_leg)
      LEG_RIGHT_UP: begin
        if (y < r) ofs_y = ofs_t'(y + 1);
        else begin
          ring_leg = LEG_TOP;
          ofs_x    = ofs_t'(r - 1);
        end
      end
      LEG_TOP: begin
        if (x > -r) ofs_x = ofs_t'(x - 1);
        else begin
          ring_leg = LEG_LEFT;
          ofs_y    = ofs_t'(r - 1);
        end
      end
      LEG_LEFT: begin
        if (y > -r) ofs_y = ofs_t'(y - 1);
        else begin
          ring_leg = LEG_BOTTOM;
          ofs_x    = ofs_t'(-r + 1);
        end
      end
      LEG_BOTTOM: begin
        if (x < r) ofs_x = ofs_t'(x + 1);
        else if (r >= 2) begin
          ring_leg = LEG_RIGHT_TAIL;
          ofs_y    = ofs_t'(-r + 1);
        end else enter_next_plane();
      end
      default: begin
        if (y < -1) ofs_y = ofs_t'(y + 1);
        else enter_next_plane();
      end
    endcase
  endfunction

  // Next voxel of the walk for one request; skips clipped positions/planes.
  function automatic voxel_result_t next_voxel(input logic again);
    voxel_result_t res;
    int  sx, sy, sz, cx, cy, cz, top, r, po, z, x, y;
    bit  plane_ok, hit, found;
    sx  = clamp_extent(ext_x);
    sy  = clamp_extent(ext_y);
    sz  = clamp_extent(ext_z);
    cx  = sx / 2;
    cy  = sy / 2;
    cz  = sz / 2;
    top = cx;
    if (cy > top) top = cy;
    if (cz > top) top = cz;
    if (again) rewind_walk();
    found = 1'b0;
    res   = '0;
    while (!found) begin
      if (walk_spent) begin
        res.vidx  = '0;
        res.spent = 1'b1;
        found     = 1'b1;
      end else if (int'(shell_num) >= top) begin
        walk_spent = 1'b1;
      end else begin
        po = int'(plane_off);
        r  = int'(shell_num) - po;
        z  = on_lower_plane ? cz - po : cz + po;
        plane_ok = z >= 0 && z < sz &&
                   (cx + r < sx || cx - r >= 0 || cy + r < sy || cy - r >= 0);
        if (!plane_ok) enter_next_plane();
        else begin
          x   = cx + ofs_x;
          y   = cy + ofs_y;
          hit = x >= 0 && x < sx && y >= 0 && y < sy;
          step_cursor(r);
          if (hit) begin
            res.vidx  = vidx_t'((z * sy + y) * sx + x);
            res.spent = 1'b0;
            found     = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Bookkeeping shared by the processes below.
  // --------------------------------------------------------------------------
  bit            pending_restarts[$];   // requests not yet offered
  voxel_result_t expected_voxels[$];    // predicted results in order
  int            requests_queued   = 0;
  int            requests_accepted = 0;
  int            results_seen      = 0;
  int            mismatches        = 0;
  int            idle_cycles       = 0;
  logic          req_fire;             // request taken at the last rising edge

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps in between.
  // A new request goes out only once the previous one was taken.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_restarts.size() > 0) begin
        in_valid <= 1'b1;
        restart  <= pending_restarts.pop_front();
        if (burst_left > 1) burst_left--;
        else begin
          burst_left = $urandom_range(1, 24);
          // about a third of the bursts run straight into the next one
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: stall mode changes every so often; twice it holds off
  // for a long stretch while requests are on offer, so the block backs up
  // and drops in_ready.
  // --------------------------------------------------------------------------
  int rx_cycle   = 0;
  int rx_mode    = 0;
  int hold_left  = 0;
  int holds_done = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left == 0 && holds_done < 2 && in_valid &&
          results_seen >= (holds_done + 1) * 150) begin
        hold_left = 250;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks results against the oldest prediction, then predicts
  // for a request taken at this edge. Also runs the no-progress watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    voxel_result_t want;
    voxel_result_t got;
    if (rst) begin
      req_fire    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      req_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        got.vidx  = voxel_index;
        got.spent = exhausted;
        if (expected_voxels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result index=%0d exhausted=%0b",
                     $realtime, got.vidx, got.spent);
        end else begin
          want = expected_voxels.pop_front();
          if (got.vidx !== want.vidx || got.spent !== want.spent) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d index exp=%0d got=%0d, exhausted exp=%0b got=%0b",
                       $realtime, results_seen, want.vidx, got.vidx,
                       want.spent, got.spent);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_voxels.insert(expected_voxels.size(), next_voxel(restart));
        requests_accepted++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequencing
  // --------------------------------------------------------------------------
  task automatic queue_request(input bit again);
    pending_restarts.insert(pending_restarts.size(), again);
    requests_queued++;
  endtask

  // Waits until every request is taken and answered, then lets it settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (requests_accepted != requests_queued || expected_voxels.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [vsig_pkg::CFG_IDX_W-1:0] which,
                           input ext_t value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
  endtask

  // Only called with the block idle, so the local copy can follow at once.
  task automatic set_extents(input int ex, ey, ez);
    write_reg(vsig_pkg::REG_SIZE_X, ext_t'(ex));
    write_reg(vsig_pkg::REG_SIZE_Y, ext_t'(ey));
    write_reg(vsig_pkg::REG_SIZE_Z, ext_t'(ez));
    @(negedge clk);
    cfg_write <= 1'b0;
    ext_x = ext_t'(ex);
    ext_y = ext_t'(ey);
    ext_z = ext_t'(ez);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return 255;
      4:       return 256;
      5:       return 257;
      6:       return 511;
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  initial begin
    int ex, ey, ez;
    int n, vol;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = vsig_pkg::REG_SIZE_X;
    cfg_data  = '0;
    ext_x     = vsig_pkg::SIZE_RESET;
    ext_y     = vsig_pkg::SIZE_RESET;
    ext_z     = vsig_pkg::SIZE_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset sizes: center point, first ring, then a restart mid-walk.
    for (int k = 0; k < 6; k++) queue_request(1'b0);
    queue_request(1'b1);
    queue_request(1'b0);
    queue_request(1'b0);
    wait_idle();

    // Zero extent along x: nothing lies in the volume.
    set_extents(0, 4, 3);
    queue_request(1'b1);
    queue_request(1'b0);
    wait_idle();

    // Single voxel volume: center at 0 on every axis, walk is empty.
    set_extents(1, 1, 1);
    queue_request(1'b1);
    queue_request(1'b0);
    wait_idle();

    // Oversized x register clamps to the maximum extent.
    set_extents(511, 3, 2);
    queue_request(1'b1);
    queue_request(1'b0);
    queue_request(1'b0);
    wait_idle();

    // Largest volume.
    set_extents(256, 256, 256);
    queue_request(1'b1);
    queue_request(1'b0);
    queue_request(1'b0);
    wait_idle();

    // Size change mid-walk: walk keeps its position, picks up new center.
    set_extents(2, 2, 2);
    queue_request(1'b1);
    queue_request(1'b0);
    queue_request(1'b0);
    wait_idle();
    set_extents(4, 4, 4);
    queue_request(1'b0);
    queue_request(1'b0);
    queue_request(1'b0);

    // Random phases: mostly small volumes with up to 48 requests, now and
    // then extreme sizes with only a few requests.
    while (requests_queued < RAND_TARGET) begin
      wait_idle();
      if ($urandom_range(0, 5) == 0) begin
        ex = pick_extreme();
        ey = pick_extreme();
        ez = pick_extreme();
        // an empty axis with huge others walks millions of clipped positions
        if (ex == 0 || ey == 0 || ez == 0) begin
          if (ex > 8) ex = $urandom_range(0, 8);
          if (ey > 8) ey = $urandom_range(0, 8);
          if (ez > 8) ez = $urandom_range(0, 8);
        end
        n = $urandom_range(1, 8);
      end else begin
        ex  = $urandom_range(1, 5);
        ey  = $urandom_range(1, 5);
        ez  = $urandom_range(1, 5);
        vol = ex * ey * ez;
        n   = $urandom_range(1, 2 * vol + 4);
        if (n > 48) n = 48;
      end
      set_extents(ex, ey, ez);
      // a quarter of the phases carry the walk over from the last sizes
      queue_request($urandom_range(0, 3) != 0);
      for (int k = 1; k < n; k++) queue_request($urandom_range(0, 24) == 0);
    end
    wait_idle();

    mismatches += expected_voxels.size();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
